### hw/rtl/esc_dec_pkg.sv
// ============================================================================
// Escape decoder package
// Shared types and character constants for the backslash-escape decoder.
// ============================================================================
package esc_dec_pkg;

    localparam int CHAR_W = 21;
    localparam int ERR_W  = 4;
    localparam int REM_W  = 4;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ERR_W-1:0]  err_t;

    // Decoder modes between characters.
    typedef enum logic [3:0] {
        MODE_IDLE = 4'd0,
        MODE_ESC  = 4'd1,
        MODE_CTRL = 4'd2,
        MODE_HEX1 = 4'd3,
        MODE_HEX2 = 4'd4,
        MODE_OCT2 = 4'd5,
        MODE_OCT3 = 4'd6,
        MODE_SKIP = 4'd7,
        MODE_PASS = 4'd8
    } mode_t;

    // Error codes carried with each result.
    localparam err_t ERR_NONE       = 4'd0;
    localparam err_t ERR_SHORT_UNI  = 4'd1;
    localparam err_t ERR_MISSING_C  = 4'd2;
    localparam err_t ERR_BAD_HEX    = 4'd3;
    localparam err_t ERR_SHORT_HEX  = 4'd4;
    localparam err_t ERR_BAD_OCT    = 4'd5;
    localparam err_t ERR_SHORT_OCT  = 4'd6;
    localparam err_t ERR_INVALID    = 4'd7;
    localparam err_t ERR_TRAILING   = 4'd8;

    // Characters that the decoder recognizes or produces.
    localparam char_t CH_BSL   = 21'h5C;
    localparam char_t CH_QMARK = 21'h3F;
    localparam char_t CH_SQUOT = 21'h27;
    localparam char_t CH_DQUOT = 21'h22;
    localparam char_t CH_LC_U  = 21'h75;
    localparam char_t CH_UC_U  = 21'h55;
    localparam char_t CH_LC_N  = 21'h6E;
    localparam char_t CH_LC_R  = 21'h72;
    localparam char_t CH_LC_A  = 21'h61;
    localparam char_t CH_LC_B  = 21'h62;
    localparam char_t CH_LC_T  = 21'h74;
    localparam char_t CH_LC_V  = 21'h76;
    localparam char_t CH_LC_E  = 21'h65;
    localparam char_t CH_LC_F  = 21'h66;
    localparam char_t CH_LC_C  = 21'h63;
    localparam char_t CH_LC_X  = 21'h78;
    localparam char_t CH_LC_Z  = 21'h7A;
    localparam char_t CH_UC_A  = 21'h41;
    localparam char_t CH_UC_F  = 21'h46;
    localparam char_t CH_D0    = 21'h30;
    localparam char_t CH_D3    = 21'h33;
    localparam char_t CH_D7    = 21'h37;
    localparam char_t CH_D9    = 21'h39;
    localparam char_t CH_ESC   = 21'h1B;

    localparam char_t CASE_OFFSET = 21'd32;
    localparam char_t CTRL_FLIP   = 21'd64;

    // One result entry.
    typedef struct packed {
        char_t ch;
        err_t  err;
        logic  last;
    } result_t;

endpackage

### hw/rtl/escape_sequence_decoder.sv
// ============================================================================
// Escape sequence decoder
// Decodes backslash escapes in a stream of wide characters, one per request.
// ============================================================================
// Usage:
//   The item channel (item_valid, item_stall, char_in, chars_after) carries
//   one character per request, with the number of characters that follow it
//   in the same string, saturated at 8. The result channel (result_valid,
//   result_stall, char_out, error_code, last_of_run) carries zero, one or
//   two results per input request; last_of_run marks the final one.
//   Each character is decoded in the cycle it is accepted and its results
//   are written into a four-entry result queue. One request is taken every
//   cycle unless the input stalls; the queue drains one result per cycle
//   unless the receiver stalls, so the two results of a universal escape
//   leave it one after the other. The input stalls only while the queue
//   holds three or more results, which happens when the receiver stalls.
//   Reset clears the queue and returns the decoder to plain-text mode.
// ============================================================================
module escape_sequence_decoder
    import esc_dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [REM_W-1:0]  chars_after,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [CHAR_W-1:0] char_out,
    output logic [ERR_W-1:0]  error_code,
    output logic              last_of_run
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    mode_t             mode_reg, mode_next;
    logic [7:0]        digit_reg, digit_next;
    logic              dvalid_reg, dvalid_next;
    logic [3:0]        pass_reg, pass_next;

    result_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    result_t           res0, res1;
    logic [1:0]        push_n;
    logic              item_acc, result_acc;
    logic [3:0]        hex_nib;
    logic              hex_ok;
    logic [2:0]        oct_dig;
    logic              oct_ok;
    char_t             upper_ch;

    assign item_acc   = item_valid && !item_stall;
    assign result_acc = result_valid && !result_stall;
    assign item_stall = (count_reg >= QCNT_W'(QDEPTH - 1));

    // Digit classification of the incoming character.
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_nib = 4'd0;
        if (char_in >= CH_D0 && char_in <= CH_D9)
            hex_nib = 4'(char_in - CH_D0);
        else if (char_in >= CH_LC_A && char_in <= CH_LC_F)
            hex_nib = 4'(char_in - CH_LC_A + 21'd10);
        else if (char_in >= CH_UC_A && char_in <= CH_UC_F)
            hex_nib = 4'(char_in - CH_UC_A + 21'd10);
        else
            hex_ok = 1'b0;

        oct_ok  = (char_in >= CH_D0 && char_in <= CH_D7);
        oct_dig = oct_ok ? 3'(char_in - CH_D0) : 3'd0;

        upper_ch = (char_in >= CH_LC_A && char_in <= CH_LC_Z) ?
                   (char_in - CASE_OFFSET) : char_in;
    end

    // Decode one character: next decoder state and up to two results.
    always_comb
    begin
        mode_next   = mode_reg;
        digit_next  = digit_reg;
        dvalid_next = dvalid_reg;
        pass_next   = pass_reg;
        push_n      = 2'd0;
        res0        = '{ch: char_in, err: ERR_NONE, last: 1'b1};
        res1        = '{ch: char_in, err: ERR_NONE, last: 1'b1};

        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_IDLE;
                push_n    = 2'd1;
                case (char_in)
                    CH_LC_U, CH_UC_U:
                    begin
                        if (chars_after >= ((char_in == CH_LC_U) ? 4'd4 : 4'd8))
                        begin
                            push_n    = 2'd2;
                            res0      = '{ch: CH_BSL, err: ERR_NONE, last: 1'b0};
                            pass_next = (char_in == CH_LC_U) ? 4'd4 : 4'd8;
                            mode_next = MODE_PASS;
                        end
                        else
                        begin
                            res0.ch  = CH_QMARK;
                            res0.err = ERR_SHORT_UNI;
                            if (chars_after != '0)
                                mode_next = MODE_SKIP;
                        end
                    end
                    CH_LC_N: res0.ch = 21'd10;
                    CH_LC_R: res0.ch = 21'd13;
                    CH_LC_A: res0.ch = 21'd7;
                    CH_LC_B: res0.ch = 21'd8;
                    CH_LC_T: res0.ch = 21'd9;
                    CH_LC_V: res0.ch = 21'd11;
                    CH_LC_E: res0.ch = CH_ESC;
                    CH_LC_F: res0.ch = 21'd12;
                    CH_BSL, CH_SQUOT, CH_DQUOT: res0.ch = char_in;
                    CH_LC_C:
                    begin
                        if (chars_after != '0)
                        begin
                            push_n    = 2'd0;
                            mode_next = MODE_CTRL;
                        end
                        else
                        begin
                            res0.ch  = CH_QMARK;
                            res0.err = ERR_MISSING_C;
                        end
                    end
                    CH_LC_X:
                    begin
                        if (chars_after >= 4'd2)
                        begin
                            push_n      = 2'd0;
                            digit_next  = 8'd0;
                            dvalid_next = 1'b1;
                            mode_next   = MODE_HEX1;
                        end
                        else
                        begin
                            res0.ch  = CH_QMARK;
                            res0.err = ERR_SHORT_HEX;
                            if (chars_after != '0)
                                mode_next = MODE_SKIP;
                        end
                    end
                    default:
                    begin
                        if (char_in >= CH_D0 && char_in <= CH_D3)
                        begin
                            if (chars_after >= 4'd2)
                            begin
                                push_n      = 2'd0;
                                digit_next  = {6'd0, oct_dig[1:0]};
                                dvalid_next = 1'b1;
                                mode_next   = MODE_OCT2;
                            end
                            else
                            begin
                                res0.ch  = CH_QMARK;
                                res0.err = ERR_SHORT_OCT;
                            end
                        end
                        else
                        begin
                            res0.ch  = CH_QMARK;
                            res0.err = ERR_INVALID;
                        end
                    end
                endcase
            end
            MODE_CTRL:
            begin
                push_n    = 2'd1;
                res0.ch   = upper_ch ^ CTRL_FLIP;
                mode_next = MODE_IDLE;
            end
            MODE_HEX1:
            begin
                digit_next  = {digit_reg[3:0], hex_nib};
                dvalid_next = dvalid_reg && hex_ok;
                mode_next   = MODE_HEX2;
            end
            MODE_HEX2:
            begin
                digit_next  = {digit_reg[3:0], hex_nib};
                dvalid_next = dvalid_reg && hex_ok;
                push_n      = 2'd1;
                res0.ch     = dvalid_next ? char_t'(digit_next) : CH_QMARK;
                res0.err    = dvalid_next ? ERR_NONE : ERR_BAD_HEX;
                mode_next   = MODE_IDLE;
            end
            MODE_OCT2:
            begin
                digit_next  = {digit_reg[4:0], oct_dig};
                dvalid_next = dvalid_reg && oct_ok;
                mode_next   = MODE_OCT3;
            end
            MODE_OCT3:
            begin
                digit_next  = {digit_reg[4:0], oct_dig};
                dvalid_next = dvalid_reg && oct_ok;
                push_n      = 2'd1;
                res0.ch     = dvalid_next ? char_t'(digit_next) : CH_QMARK;
                res0.err    = dvalid_next ? ERR_NONE : ERR_BAD_OCT;
                mode_next   = MODE_IDLE;
            end
            MODE_SKIP:
            begin
                mode_next = MODE_IDLE;
            end
            MODE_PASS:
            begin
                push_n = 2'd1;
                if (pass_reg != 4'd0)
                    pass_next = pass_reg - 4'd1;
                if (pass_next == 4'd0)
                    mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                push_n    = 2'd1;
                if (char_in == CH_BSL)
                begin
                    if (chars_after == '0)
                    begin
                        res0.ch  = CH_QMARK;
                        res0.err = ERR_TRAILING;
                    end
                    else
                    begin
                        push_n    = 2'd0;
                        mode_next = MODE_ESC;
                    end
                end
            end
        endcase
    end

    // Decoder state, updated on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            digit_reg  <= 8'd0;
            dvalid_reg <= 1'b1;
            pass_reg   <= 4'd0;
        end
        else if (item_acc)
        begin
            mode_reg   <= mode_next;
            digit_reg  <= digit_next;
            dvalid_reg <= dvalid_next;
            pass_reg   <= pass_next;
        end
    end

    // Result queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (item_acc)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (result_acc)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(item_acc ? push_n : 2'd0)
                         - QCNT_W'(result_acc);
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (item_acc && push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (item_acc && push_n == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    assign result_valid = (count_reg != '0);
    assign char_out     = queue_reg[rd_ptr_reg].ch;
    assign error_code   = queue_reg[rd_ptr_reg].err;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

`ifndef NO_ASSERTIONS
    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // A plain character taken in text mode makes a result valid next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && mode_reg == MODE_IDLE && char_in != CH_BSL |=> result_valid)
        else $error("plain character produced no result");

    // Pass-through mode always has digits left to forward.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_PASS |-> pass_reg != 4'd0)
        else $error("pass-through mode with zero count");
`endif

endmodule
